>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, skipped while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// Check on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> rtl/core/bgm_pkg.sv
// ----------------------------------------------------------------------------
// bgm_pkg
// Types, codes and defaults shared by the button gesture matcher.
// ----------------------------------------------------------------------------
package bgm_pkg;

    localparam int BUTTONS_DEF = 4;
    localparam int ENTRIES_DEF = 8;

    localparam int PIN_W    = 4;
    localparam int MODES_W  = 8;
    localparam int IDX_W    = 3;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int COUNT_W  = 4;
    localparam int TABLE_W  = 64;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE    = 2'd3;

    // Register reset values
    localparam logic [MS_W-1:0]    DEBOUNCE_RST = 16'd50;
    localparam logic [MS_W-1:0]    LONG_MS_RST  = 16'd700;
    localparam logic [COUNT_W-1:0] COUNT_RST    = 4'd0;
    localparam logic [TABLE_W-1:0] TABLE_RST    = 64'd0;

    // Button modes
    localparam logic [1:0] MODE_RELEASED = 2'd0;
    localparam logic [1:0] MODE_HELD     = 2'd1;
    localparam logic [1:0] MODE_RISING   = 2'd2;
    localparam logic [1:0] MODE_FALLING  = 2'd3;

    // Combo gesture codes
    localparam logic [1:0] CODE_IGNORE     = 2'd0;
    localparam logic [1:0] CODE_CLICK      = 2'd1;
    localparam logic [1:0] CODE_HOLD_CLICK = 2'd2;
    localparam logic [1:0] CODE_HOLD       = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [PIN_W-1:0]  pin_levels;
    } t_in_item;

    typedef struct packed {
        logic [MODES_W-1:0] button_modes;
        logic               matched;
        logic [IDX_W-1:0]   match_index;
    } t_out_item;

    // What one button lane reports for the current item
    typedef struct packed {
        logic [1:0] mode;
        logic       long_press;
    } t_lane_out;

endpackage

>>> rtl/core/bgm_lane.sv
// ----------------------------------------------------------------------------
// bgm_lane
// One button: classify the sampled level and track the press timestamp.
// ----------------------------------------------------------------------------
module bgm_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_cur,
    input  logic                        i_last,
    input  logic [bgm_pkg::TIME_W-1:0]  i_now,
    input  logic [bgm_pkg::MS_W-1:0]    i_long_ms,
    output bgm_pkg::t_lane_out          o_lane
);

    logic [1:0]                 r_mode;
    logic [1:0]                 n_mode;
    logic [bgm_pkg::TIME_W-1:0] r_stamp;
    logic [bgm_pkg::TIME_W-1:0] n_stamp;
    logic [bgm_pkg::TIME_W-1:0] w_ptime;

    // Stamp follows the mode left by the previous item
    always_comb begin
        case (r_mode)
            bgm_pkg::MODE_RISING:  n_stamp = i_now;
            bgm_pkg::MODE_FALLING: n_stamp = '0;
            default:               n_stamp = r_stamp;
        endcase
    end

    always_comb begin
        if (i_cur != i_last) begin
            n_mode = i_last ? bgm_pkg::MODE_FALLING : bgm_pkg::MODE_RISING;
        end else begin
            n_mode = i_cur ? bgm_pkg::MODE_HELD : bgm_pkg::MODE_RELEASED;
        end
    end

    // A zero stamp means no press
    assign w_ptime = (n_stamp != '0) ? (i_now - n_stamp) : '0;

    assign o_lane.mode       = n_mode;
    assign o_lane.long_press =
        w_ptime >= {{(bgm_pkg::TIME_W-bgm_pkg::MS_W){1'b0}}, i_long_ms};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= bgm_pkg::MODE_RELEASED;
            r_stamp <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_stamp <= n_stamp;
        end
    end

endmodule

>>> rtl/core/bgm_merge.sv
// ----------------------------------------------------------------------------
// bgm_merge
// Match every combo entry against the lane results and pick the first hit.
// ----------------------------------------------------------------------------
module bgm_merge #(
    parameter int BUTTONS = bgm_pkg::BUTTONS_DEF,
    parameter int ENTRIES = bgm_pkg::ENTRIES_DEF
) (
    input  logic [2*BUTTONS-1:0]           i_modes,
    input  logic [BUTTONS-1:0]             i_long,
    input  logic [bgm_pkg::TABLE_W-1:0]    i_table,
    input  logic [bgm_pkg::COUNT_W-1:0]    i_count,
    output logic                           o_matched,
    output logic [bgm_pkg::IDX_W-1:0]      o_index
);

    localparam logic [bgm_pkg::COUNT_W-1:0] MAX_COUNT = bgm_pkg::COUNT_W'(ENTRIES);

    logic [ENTRIES-1:0]            w_hit;
    logic [bgm_pkg::COUNT_W-1:0]   w_count;

    for (genvar e = 0; e < ENTRIES; e++) begin : g_entry
        logic [BUTTONS-1:0] w_btn_hit;
        for (genvar b = 0; b < BUTTONS; b++) begin : g_btn
            localparam int POS = 2 * BUTTONS * e + 2 * b;
            logic [1:0] w_code;
            logic [1:0] w_mode;
            if (POS < bgm_pkg::TABLE_W) begin : g_in
                assign w_code = i_table[POS +: 2];
            end else begin : g_out
                assign w_code = bgm_pkg::CODE_IGNORE;
            end
            assign w_mode = i_modes[2*b +: 2];
            always_comb begin
                case (w_code)
                    bgm_pkg::CODE_CLICK:
                        w_btn_hit[b] = (w_mode == bgm_pkg::MODE_FALLING) && !i_long[b];
                    bgm_pkg::CODE_HOLD_CLICK:
                        w_btn_hit[b] = (w_mode == bgm_pkg::MODE_FALLING) && i_long[b];
                    bgm_pkg::CODE_HOLD:
                        w_btn_hit[b] = (w_mode == bgm_pkg::MODE_HELD) && i_long[b];
                    default:
                        w_btn_hit[b] = 1'b0;
                endcase
            end
        end
        assign w_hit[e] = |w_btn_hit;
    end

    assign w_count = (i_count > MAX_COUNT) ? MAX_COUNT : i_count;

    // Lowest scanned entry with a hit wins
    always_comb begin
        o_matched = 1'b0;
        o_index   = '0;
        for (int e = ENTRIES - 1; e >= 0; e--) begin
            if (w_hit[e] && (bgm_pkg::COUNT_W'(e) < w_count)) begin
                o_matched = 1'b1;
                o_index   = bgm_pkg::IDX_W'(e);
            end
        end
    end

endmodule

>>> rtl/core/button_gesture_matcher.sv
// ----------------------------------------------------------------------------
// button_gesture_matcher
// Debounce four buttons, classify their gestures and match a combo table.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (now_ms, pin_levels) arrive on i_in_valid / i_in_item and are
//   taken at an edge with i_in_valid high and o_in_stall low. Each item gives
//   exactly one result item on o_out_valid / o_out_item, taken when
//   i_out_stall is low.
//   The button lanes update mode and press stamp when an item is accepted and
//   their results are registered in the lane stage, the combo merge runs on
//   that stage, and the result is loaded into the output register.
//   Throughput is one item per cycle unless the receiver stalls; each lane
//   finishes its state update (debounce, mode, stamp) at the accept edge.
//   While the receiver stalls, the result holds in the output register and
//   one more item can still be taken into the lane stage; o_in_stall rises
//   only when both stages are full.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
//   the edge; write them only while the block is idle.
//   Reset (synchronous, active low) empties both stages, clears all
//   button state and loads the register defaults.
// ----------------------------------------------------------------------------
module button_gesture_matcher #(
    parameter int BUTTONS = bgm_pkg::BUTTONS_DEF,
    parameter int ENTRIES = bgm_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bgm_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bgm_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_we,
    input  logic [bgm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bgm_pkg::CFG_W-1:0]       i_cfg_data
);

    // Configuration registers
    logic [bgm_pkg::MS_W-1:0]    r_debounce;
    logic [bgm_pkg::MS_W-1:0]    r_long_ms;
    logic [bgm_pkg::COUNT_W-1:0] r_count;
    logic [bgm_pkg::TABLE_W-1:0] r_table;

    // Debounce state
    logic [bgm_pkg::TIME_W-1:0]  r_sample_time;
    logic [bgm_pkg::TIME_W-1:0]  n_sample_time;
    logic [BUTTONS-1:0]          r_sampled;
    logic [BUTTONS-1:0]          n_sampled;
    logic [BUTTONS-1:0]          r_prev;

    // Lane stage and output stage
    logic                        r_p_valid;
    logic [2*BUTTONS-1:0]        r_p_modes;
    logic [BUTTONS-1:0]          r_p_long;
    logic                        r_out_valid;
    bgm_pkg::t_out_item          r_out;

    logic                        w_accept;
    logic                        w_out_ready;
    logic                        w_p_ready;
    logic [bgm_pkg::TIME_W-1:0]  w_since;
    logic                        w_resample;
    logic [BUTTONS-1:0]          w_pins;
    bgm_pkg::t_lane_out          w_lane [BUTTONS];
    logic [2*BUTTONS-1:0]        w_modes;
    logic [BUTTONS-1:0]          w_long;
    logic                        w_matched;
    logic [bgm_pkg::IDX_W-1:0]   w_index;
    logic [bgm_pkg::MODES_W-1:0] w_modes_out;

    // Handshake: a stage advances when the one after it is free or drains
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_p_ready   = !r_p_valid || w_out_ready;
    assign o_in_stall  = !w_p_ready;
    assign w_accept    = i_in_valid && w_p_ready;

    // Buttons past the input width see a released level
    for (genvar b = 0; b < BUTTONS; b++) begin : g_pins
        if (b < bgm_pkg::PIN_W) begin : g_real
            assign w_pins[b] = i_in_item.pin_levels[b];
        end else begin : g_none
            assign w_pins[b] = 1'b0;
        end
    end

    // Resample once more than debounce_ms has gone by, modulo 2^32
    assign w_since    = i_in_item.now_ms - r_sample_time;
    assign w_resample =
        w_since > {{(bgm_pkg::TIME_W-bgm_pkg::MS_W){1'b0}}, r_debounce};
    assign n_sampled     = w_resample ? w_pins : r_sampled;
    assign n_sample_time = w_resample ? i_in_item.now_ms : r_sample_time;

    for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
        bgm_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (w_accept),
            .i_cur      (n_sampled[b]),
            .i_last     (r_prev[b]),
            .i_now      (i_in_item.now_ms),
            .i_long_ms  (r_long_ms),
            .o_lane     (w_lane[b])
        );
        assign w_modes[2*b +: 2] = w_lane[b].mode;
        assign w_long[b]         = w_lane[b].long_press;
    end

    bgm_merge #(
        .BUTTONS (BUTTONS),
        .ENTRIES (ENTRIES)
    ) u_merge (
        .i_modes   (r_p_modes),
        .i_long    (r_p_long),
        .i_table   (r_table),
        .i_count   (r_count),
        .o_matched (w_matched),
        .o_index   (w_index)
    );

    // Only the first four buttons are shown; missing ones read released
    for (genvar b = 0; b < bgm_pkg::MODES_W / 2; b++) begin : g_show
        if (b < BUTTONS) begin : g_real
            assign w_modes_out[2*b +: 2] = r_p_modes[2*b +: 2];
        end else begin : g_none
            assign w_modes_out[2*b +: 2] = bgm_pkg::MODE_RELEASED;
        end
    end

    // Configuration writes; unknown indexes cannot occur on a 2-bit port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= bgm_pkg::DEBOUNCE_RST;
            r_long_ms  <= bgm_pkg::LONG_MS_RST;
            r_count    <= bgm_pkg::COUNT_RST;
            r_table    <= bgm_pkg::TABLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bgm_pkg::REG_DEBOUNCE: r_debounce <= i_cfg_data[bgm_pkg::MS_W-1:0];
                bgm_pkg::REG_LONG_MS:  r_long_ms  <= i_cfg_data[bgm_pkg::MS_W-1:0];
                bgm_pkg::REG_COUNT:    r_count    <= i_cfg_data[bgm_pkg::COUNT_W-1:0];
                bgm_pkg::REG_TABLE:    r_table    <= i_cfg_data[bgm_pkg::TABLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Debounce state advances with every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_time <= '0;
            r_sampled     <= '0;
            r_prev        <= '0;
        end else if (w_accept) begin
            r_sample_time <= n_sample_time;
            r_sampled     <= n_sampled;
            r_prev        <= n_sampled;
        end
    end

    // Lane stage: hold what the lanes found for the merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_p_ready) begin
            r_p_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_modes <= w_modes;
            r_p_long  <= w_long;
        end
    end

    // Output stage: load on drain, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_p_valid) begin
            r_out.button_modes <= w_modes_out;
            r_out.matched      <= w_matched;
            r_out.match_index  <= w_index;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> rtl/core/bgm_checker.sv
// ----------------------------------------------------------------------------
// bgm_checker
// Port-level checks on the button gesture matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgm_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  bgm_pkg::t_out_item  o_out_item
);

    // Reset empties the output stage
    `ASSERT_CLK_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid)

    // A stalled result stays offered
    `ASSERT_CLK(a_stall_keeps_valid, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid)

    // A stalled result keeps its payload
    `ASSERT_CLK(a_stall_keeps_item, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> $stable(o_out_item))

    // No match reports index zero
    `ASSERT_CLK(a_nomatch_index, i_clk, i_rst_n,
        o_out_valid && !o_out_item.matched |-> o_out_item.match_index == '0)

endmodule

bind button_gesture_matcher bgm_checker u_bgm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

>>> sim/gesture_tb_pkg.sv
// ----------------------------------------------------------------------------
// gesture_tb_pkg
// Gesture tracker for the matcher bench: mirrors the debounce, mode and
// press-stamp state plus the combo scan, and holds the reports still owed.
// ----------------------------------------------------------------------------
package gesture_tb_pkg;

    import bgm_pkg::*;

    class gesture_tracker;

        logic [MS_W-1:0]    debounce;
        logic [MS_W-1:0]    long_ms;
        logic [COUNT_W-1:0] entry_cnt;
        logic [TABLE_W-1:0] combos;

        logic [TIME_W-1:0]  sample_time;
        logic [PIN_W-1:0]   sampled;
        logic [PIN_W-1:0]   prev_lv;
        logic [1:0]         mode_now [BUTTONS_DEF];
        logic [TIME_W-1:0]  stamp [BUTTONS_DEF];

        t_out_item          reports_due [$];
        int                 mismatches;

        function new();
            debounce    = DEBOUNCE_RST;
            long_ms     = LONG_MS_RST;
            entry_cnt   = COUNT_RST;
            combos      = TABLE_RST;
            sample_time = '0;
            sampled     = '0;
            prev_lv     = '0;
            mismatches  = 0;
            for (int b = 0; b < BUTTONS_DEF; b++) begin
                mode_now[b] = MODE_RELEASED;
                stamp[b]    = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_DEBOUNCE: debounce  = data[MS_W-1:0];
                REG_LONG_MS:  long_ms   = data[MS_W-1:0];
                REG_COUNT:    entry_cnt = data[COUNT_W-1:0];
                REG_TABLE:    combos    = data[TABLE_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the button state by one accepted item and queue its report.
        function void absorb_sample(t_in_item it);
            logic [TIME_W-1:0] ptime [BUTTONS_DEF];
            logic [TIME_W-1:0] elapsed;
            logic              cur;
            logic              last;
            logic              longp;
            logic [1:0]        code;
            int                cnt;
            t_out_item         rep;
            rep = '0;
            elapsed = it.now_ms - sample_time;
            if (elapsed > {16'd0, debounce}) begin
                sampled     = it.pin_levels;
                sample_time = it.now_ms;
            end
            for (int b = 0; b < BUTTONS_DEF; b++) begin
                cur  = sampled[b];
                last = prev_lv[b];
                // stamp follows the mode of the previous item
                if (mode_now[b] == MODE_RISING)
                    stamp[b] = it.now_ms;
                else if (mode_now[b] == MODE_FALLING)
                    stamp[b] = '0;
                if (cur != last)
                    mode_now[b] = last ? MODE_FALLING : MODE_RISING;
                else
                    mode_now[b] = cur ? MODE_HELD : MODE_RELEASED;
                prev_lv[b] = cur;
                ptime[b] = (stamp[b] != '0) ? it.now_ms - stamp[b] : '0;
                rep.button_modes[2*b +: 2] = mode_now[b];
            end
            cnt = (entry_cnt > ENTRIES_DEF) ? ENTRIES_DEF : int'(entry_cnt);
            for (int e = 0; e < cnt && !rep.matched; e++) begin
                for (int b = 0; b < BUTTONS_DEF; b++) begin
                    code  = combos[2*BUTTONS_DEF*e + 2*b +: 2];
                    longp = ptime[b] >= {16'd0, long_ms};
                    if (code == CODE_CLICK && mode_now[b] == MODE_FALLING && !longp)
                        rep.matched = 1'b1;
                    else if (code == CODE_HOLD_CLICK && mode_now[b] == MODE_FALLING && longp)
                        rep.matched = 1'b1;
                    else if (code == CODE_HOLD && mode_now[b] == MODE_HELD && longp)
                        rep.matched = 1'b1;
                end
                if (rep.matched)
                    rep.match_index = IDX_W'(e);
            end
            reports_due.push_back(rep);
        endfunction

        function void verify_report(t_out_item got);
            t_out_item want;
            if (reports_due.size() == 0) begin
                $display("%0t: report with none owed, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = reports_due.pop_front();
            if (got.button_modes !== want.button_modes) begin
                $display("%0t: button_modes expected %h actual %h",
                         $time, want.button_modes, got.button_modes);
                mismatches++;
            end
            if (got.matched !== want.matched) begin
                $display("%0t: matched expected %b actual %b", $time, want.matched, got.matched);
                mismatches++;
            end
            if (got.match_index !== want.match_index) begin
                $display("%0t: match_index expected %0d actual %0d",
                         $time, want.match_index, got.match_index);
                mismatches++;
            end
        endfunction

        function int owed();
            return reports_due.size();
        endfunction

    endclass

endpackage

>>> sim/tb_button_gesture_matcher.sv
// ----------------------------------------------------------------------------
// tb_button_gesture_matcher
// Drives timed button samples into the gesture matcher under random idling
// and back-pressure, predicts every report with the gesture tracker and
// compares each report field by field.
// ----------------------------------------------------------------------------
module tb_button_gesture_matcher;

    timeunit 1ns;
    timeprecision 1ps;

    import bgm_pkg::*;
    import gesture_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 260;
    localparam int PHASES       = 7;
    localparam int SETTLE       = 6;     // margin for the pipeline to drain

    logic                 i_clk     = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_item   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_item;

    gesture_tracker       tracker = new();
    t_in_item             samples_q [$];

    // Phase knobs, changed by the main sequence only while the block is idle.
    logic                 idle_on = 1'b1;

    int                   send_gap      = 0;
    int                   stall_left    = 0;
    int                   long_left     = 0;
    logic                 long_hold_done = 1'b0;
    int                   reports_taken = 0;
    int                   cycle_count   = 0;

    button_gesture_matcher dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: end the run if it drags far past the slowest correct pace.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("button_gesture_matcher verification failed");
            $finish;
        end
    end

    // Sender: note each accepted item, hold a stalled one, then offer the
    // next sample or open an idle burst.
    always @(posedge i_clk) begin : feed_samples
        logic taken;
        if (rst_n) begin
            taken = in_valid && !o_in_stall;
            if (taken)
                tracker.absorb_sample(in_item);
            if (!in_valid || taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (samples_q.size() > 0) begin
                    if (idle_on && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 14) - 1;
                        in_valid <= 1'b0;
                    end else begin
                        in_item  <= samples_q.pop_front();
                        in_valid <= 1'b1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each taken report, stall in bursts, and once hold off
    // long enough that both stages fill and the input stalls.
    always @(posedge i_clk) begin : take_reports
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                tracker.verify_report(o_out_item);
                reports_taken++;
            end
            if (!long_hold_done && reports_taken >= 700) begin
                long_hold_done = 1'b1;
                long_left = 300;
            end
            if (long_left > 0) begin
                long_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_sample(logic [TIME_W-1:0] now, logic [PIN_W-1:0] pins);
        samples_q.push_back(t_in_item'({now, pins}));
    endtask

    // Wait until every sample is taken and every report checked, then let
    // the pipeline settle before touching registers.
    task automatic wait_idle();
        @(negedge i_clk);
        while (samples_q.size() > 0 || in_valid || tracker.owed() > 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        tracker.write_reg(idx, data);
    endtask

    // Write all four registers; junk puts noise in the unused upper bits.
    task automatic configure(logic [MS_W-1:0] deb, logic [MS_W-1:0] hold,
                             logic [COUNT_W-1:0] cnt, logic [TABLE_W-1:0] tbl,
                             logic junk);
        logic [CFG_W-1:0] noise;
        noise = junk ? {$urandom, $urandom} : '0;
        write_reg(REG_DEBOUNCE, {noise[CFG_W-1:MS_W], deb});
        write_reg(REG_LONG_MS,  {noise[CFG_W-1:MS_W], hold});
        write_reg(REG_COUNT,    {noise[CFG_W-1:COUNT_W], cnt});
        write_reg(REG_TABLE,    tbl);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Combo table with mostly ignored buttons and some of each gesture.
    function automatic logic [TABLE_W-1:0] random_combos();
        logic [TABLE_W-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < TABLE_W / 2; i++)
            if ($urandom_range(0, 2) == 0)
                tbl[2*i +: 2] = 2'($urandom_range(1, 3));
        return tbl;
    endfunction

    // Realistic button activity: time moves forward in steps of varied size,
    // buttons go down and up; a few items are noise or level jumps.
    task automatic queue_gestures(int n, logic [TIME_W-1:0] start);
        logic [TIME_W-1:0] t;
        logic [PIN_W-1:0]  lv;
        int                r;
        t  = start;
        lv = '0;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                push_sample($urandom, 4'($urandom));
            end else begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    t += $urandom_range(0, 60);
                else if (r < 9)
                    t += $urandom_range(50, 1500);
                else
                    t += $urandom_range(0, 70000);
                r = $urandom_range(0, 99);
                if (r < 30)
                    lv[2'($urandom_range(0, PIN_W - 1))] ^= 1'b1;
                else if (r < 35)
                    lv = 4'($urandom);
                push_sample(t, lv);
            end
        end
    endtask

    initial begin : main_sequence
        logic [TABLE_W-1:0] tbl;
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        wait_idle();

        // Directed: one gesture per button, each in its own table entry, plus a
        // second for button 3 in entry 7; entry count above the table size; stamp taken at time zero.
        tbl = '0;
        tbl[1:0]   = CODE_CLICK;       // entry 0, button 0
        tbl[11:10] = CODE_HOLD_CLICK;  // entry 1, button 1
        tbl[21:20] = CODE_HOLD;        // entry 2, button 2
        tbl[31:30] = CODE_CLICK;       // entry 3, button 3
        tbl[63:62] = CODE_HOLD_CLICK;  // entry 7, button 3
        configure(16'd0, 16'd100, 4'd9, tbl, 1'b1);
        push_sample(32'd10, 4'b0001);
        push_sample(32'd20, 4'b0001);
        push_sample(32'd50, 4'b0000);   // short press: click
        push_sample(32'd60, 4'b0000);
        push_sample(32'd70, 4'b0010);
        push_sample(32'd80, 4'b0010);
        push_sample(32'd300, 4'b0010);
        push_sample(32'd400, 4'b0000);  // long press released: hold-click
        push_sample(32'd410, 4'b0100);
        push_sample(32'd420, 4'b0100);
        push_sample(32'd600, 4'b0100);  // still down past the limit: hold
        push_sample(32'd600, 4'b0000);  // no time passed, no resample
        push_sample(32'd700, 4'b0000);
        push_sample(32'd710, 4'b1000);
        push_sample(32'd720, 4'b1000);
        push_sample(32'd730, 4'b0000);
        push_sample(32'hFFFF_FFFF, 4'b1111);
        push_sample(32'd0, 4'b1111);    // press stamped at zero reads as none
        push_sample(32'd5000, 4'b1111);
        push_sample(32'h8000_0000, 4'b0000);
        wait_idle();

        // Directed: widest debounce and hold limit, no entries scanned.
        configure(16'hFFFF, 16'hFFFF, 4'd0, {TABLE_W{1'b1}}, 1'b0);
        push_sample(32'd1, 4'b1111);
        push_sample(32'h0001_0000, 4'b1010);
        push_sample(32'h7FFF_FFFF, 4'b0101);
        push_sample(32'h7FFF_FFFF, 4'b0000);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_on = (ph != 3) && (ph != PHASES - 1);
            case (ph)
                0: configure(16'($urandom_range(0, 80)), 16'($urandom_range(100, 1200)),
                             4'd8, random_combos(), 1'b0);
                1: configure(16'd0, 16'd0, 4'd15, {TABLE_W{1'b1}}, 1'b1);
                2: configure(16'hFFFF, 16'hFFFF, 4'd1, random_combos(), 1'b0);
                3: configure(16'($urandom_range(0, 100)), 16'($urandom_range(0, 2000)),
                             4'($urandom_range(0, 15)), random_combos(), 1'b0);
                4: configure(16'($urandom_range(0, 30)), 16'($urandom_range(200, 900)),
                             4'd8, random_combos(), 1'b1);
                5: configure(16'd20, 16'd700, 4'd9, {(TABLE_W / 2){2'b01}}, 1'b0);
                default: configure(16'($urandom), 16'($urandom_range(0, 1500)),
                                   4'($urandom_range(1, 8)), random_combos(), 1'b0);
            endcase
            // start one phase just below the wrap of the millisecond counter
            queue_gestures(PHASE_ITEMS, (ph == 2) ? 32'hFFFF_0000 : $urandom);
            wait_idle();
        end

        if (tracker.mismatches == 0 && tracker.owed() == 0) begin
            $display("button_gesture_matcher verification clean");
        end else begin
            $display("button_gesture_matcher verification failed");
        end
        $finish;
    end

endmodule
